// ----- src/zoet_pkg.sv -----
// zoet_pkg: shared types, constants and helpers for the zone occupancy tracker
// no dependencies; imported by every other file of the block
`default_nettype none

package zoet_pkg;

  // default sizing
  localparam int SLOTS_DEF      = 64;
  localparam int COORD_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 32;
  localparam int POS_W     = 32;
  localparam int TALLY_W   = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BOX   = 6;
  localparam int NUM_AXES  = 3;

  // item commands
  typedef logic [CMD_W-1:0] zoet_cmd_t;
  localparam zoet_cmd_t CMD_BEGIN  = 2'd0;
  localparam zoet_cmd_t CMD_SAMPLE = 2'd1;
  localparam zoet_cmd_t CMD_END    = 2'd2;

  // operations broadcast along the slot chain
  typedef logic [1:0] zoet_op_t;
  localparam zoet_op_t OP_HOLD   = 2'd0;
  localparam zoet_op_t OP_BEGIN  = 2'd1;
  localparam zoet_op_t OP_SAMPLE = 2'd2;
  localparam zoet_op_t OP_SHIFT  = 2'd3;

  // contents of one slot
  typedef struct packed {
    logic [ID_W-1:0] obj;
    logic            was_in;
    logic            now_in;
    logic            seen;
  } zoet_slot_t;

  // control broadcast to every cell
  typedef struct packed {
    zoet_op_t op;
    logic     in_box;
    logic     hit;
    logic     kept;
  } zoet_ctl_t;

  // saturating tally increment
  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    logic [TALLY_W-1:0] r;
    r = (v == {TALLY_W{1'b1}}) ? v : v + TALLY_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/zoet_if.sv -----
// zoet_if: valid/ready channel interfaces for sample items and frame results
// depends on zoet_pkg
`default_nettype none

interface zoet_item_if import zoet_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [ID_W-1:0]         object_id;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, cmd, object_id, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, cmd, object_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface zoet_result_if import zoet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TALLY_W-1:0] entered;
  logic [TALLY_W-1:0] left;

  modport source (output valid, entered, left, input ready);
  modport sink   (input valid, entered, left, output ready);
endinterface

`default_nettype wire

// ----- src/zone_occupancy_edge_tracker.sv -----
// sequence: frame begin and object samples are accepted, then applied in ST_WORK
// frame end: ST_WORK, ST_SWEEP (skipped if no slot is used), ST_EMIT loads result;
// the compaction sweep pops one slot per cycle from the head of the cell chain
// flow: ready is high only in ST_IDLE, so an item is taken only once the last is done
// reset: synchronous active-high rst clears marks, counts, tallies and box bounds;
// slot ids are left as they are
`default_nettype none

module zone_occupancy_edge_tracker import zoet_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  zoet_item_if.sink                 item,
  zoet_result_if.source             result
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int EXT_W = POS_W + 1;

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WORK  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;

  // box bounds, min/max pairs per axis
  logic [CFG_W-1:0]   box [NUM_BOX];

  // registered item
  zoet_cmd_t          cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [POS_W-1:0]   pos_q [NUM_AXES];

  // table bookkeeping
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   cnt;
  logic [TALLY_W-1:0] enter_tally;
  logic [TALLY_W-1:0] exit_tally;

  // result register
  logic               out_valid;
  logic [TALLY_W-1:0] out_entered;
  logic [TALLY_W-1:0] out_left;

  // chain wiring
  zoet_slot_t         slots [SLOTS];
  logic [SLOTS-1:0]   match_vec;
  logic [SLOTS-1:0]   was_vec;
  zoet_ctl_t          ctl;
  logic [CNT_W-1:0]   tail;
  logic [NUM_AXES-1:0] axis_in;
  logic               in_box;
  logic               hit;
  logic               room;
  logic               was_sel;
  logic               kept;
  logic               out_free;

  assign item.ready     = (state == ST_IDLE);
  assign result.valid   = out_valid;
  assign result.entered = out_entered;
  assign result.left    = out_left;

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BOX; i++) begin
        box[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_BOX))) begin
      box[cfg_index] <= cfg_data;
    end
  end

  // ---------------- box test ----------------
  // if COORD_BITS <= POS_W, each coordinate is sign-extended from COORD_BITS and compared as signed
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [EXT_W-1:0] p_e;
    logic signed [EXT_W-1:0] lo_e;
    logic signed [EXT_W-1:0] hi_e;
    if (COORD_BITS <= POS_W) begin : g_narrow
      assign p_e  = EXT_W'(signed'(pos_q[a][COORD_BITS-1:0]));
      assign lo_e = EXT_W'(signed'(box[2*a][COORD_BITS-1:0]));
      assign hi_e = EXT_W'(signed'(box[2*a+1][COORD_BITS-1:0]));
    end else begin : g_wide
      // upper bits of the window are zero, so values stay non-negative
      assign p_e  = signed'({1'b0, pos_q[a]});
      assign lo_e = signed'({1'b0, box[2*a]});
      assign hi_e = signed'({1'b0, box[2*a+1]});
    end
    assign axis_in[a] = (p_e >= lo_e) && (p_e <= hi_e);
  end

  assign in_box = &axis_in;

  // ---------------- slot chain ----------------
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    zoet_slot_t right_in;
    if (i == SLOTS - 1) begin : g_end
      assign right_in = zoet_slot_t'('0);
    end else begin : g_mid
      assign right_in = slots[i+1];
    end

    zoet_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .id    (id_q),
      .used  (used),
      .tail  (tail),
      .head  (slots[0]),
      .right (right_in),
      .slot  (slots[i]),
      .match (match_vec[i])
    );

    assign was_vec[i] = slots[i].was_in;
  end

  // ids are unique among live slots, so at most one cell matches
  assign hit     = |match_vec;
  assign was_sel = |(match_vec & was_vec);
  assign room    = used < CNT_W'(SLOTS);
  assign kept    = slots[0].seen;
  assign tail    = len - CNT_W'(1);

  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.in_box = in_box;
    ctl.hit    = hit;
    ctl.kept   = kept;
    if (state == ST_WORK && cmd_q == CMD_BEGIN) begin
      ctl.op = OP_BEGIN;
    end else if (state == ST_WORK && cmd_q == CMD_SAMPLE) begin
      ctl.op = OP_SAMPLE;
    end else if (state == ST_SWEEP) begin
      ctl.op = OP_SHIFT;
    end
  end

  // ---------------- sequencing ----------------
  assign out_free = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (cmd_q == CMD_END) begin
          state_next = (used == '0) ? ST_EMIT : ST_SWEEP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (cnt + CNT_W'(1) == used) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture on transaction
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      cmd_q    <= item.cmd;
      id_q     <= item.object_id;
      pos_q[0] <= item.pos_x;
      pos_q[1] <= item.pos_y;
      pos_q[2] <= item.pos_z;
    end
  end

  // counts and tallies
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      len         <= '0;
      cnt         <= '0;
      enter_tally <= '0;
      exit_tally  <= '0;
    end else begin
      unique case (state)
        ST_WORK: begin
          if (cmd_q == CMD_BEGIN) begin
            enter_tally <= '0;
            exit_tally  <= '0;
          end else if (cmd_q == CMD_SAMPLE && (hit || room)) begin
            if (!hit) begin
              used <= used + CNT_W'(1);
            end
            if (in_box && !was_sel) begin
              enter_tally <= sat_inc(enter_tally);
            end
            if (!in_box && was_sel) begin
              exit_tally <= sat_inc(exit_tally);
            end
          end else if (cmd_q == CMD_END) begin
            len <= used;
            cnt <= '0;
          end
        end
        ST_SWEEP: begin
          // head slot leaves; a dropped one that was inside counts as an exit
          cnt <= cnt + CNT_W'(1);
          if (!kept) begin
            len <= len - CNT_W'(1);
            if (slots[0].was_in) begin
              exit_tally <= sat_inc(exit_tally);
            end
          end
          if (cnt + CNT_W'(1) == used) begin
            used <= kept ? len : len - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_entered <= enter_tally;
      out_left    <= exit_tally;
    end
  end

endmodule

`default_nettype wire

// ----- src/zoet_cell.sv -----
// zoet_cell: one slot of the tracking chain, holds an id and its three marks
// depends on zoet_pkg
`default_nettype none

module zoet_cell import zoet_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX   = 0,
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire zoet_ctl_t        ctl,
  input  wire logic [ID_W-1:0]  id,
  input  wire logic [CNT_W-1:0] used,
  input  wire logic [CNT_W-1:0] tail,
  input  wire zoet_slot_t       head,
  input  wire zoet_slot_t       right,
  output zoet_slot_t            slot,
  output logic                  match
);

  logic [ID_W-1:0] obj;
  logic            was_in;
  logic            now_in;
  logic            seen;
  zoet_slot_t      slot_next;
  logic            live;
  logic            append_here;
  logic            at_tail;

  assign slot        = '{obj: obj, was_in: was_in, now_in: now_in, seen: seen};
  assign live        = CNT_W'(IDX) < used;
  assign match       = live && (obj == id);
  assign append_here = !ctl.hit && (CNT_W'(IDX) == used);
  assign at_tail     = CNT_W'(IDX) == tail;

  always_comb begin
    slot_next = slot;
    unique case (ctl.op)
      OP_BEGIN: begin
        if (live) begin
          slot_next.was_in = now_in;
          slot_next.now_in = 1'b0;
          slot_next.seen   = 1'b0;
        end
      end
      OP_SAMPLE: begin
        if (match) begin
          slot_next.now_in = ctl.in_box;
          slot_next.seen   = 1'b1;
        end else if (append_here) begin
          slot_next.obj    = id;
          slot_next.was_in = 1'b0;
          slot_next.now_in = ctl.in_box;
          slot_next.seen   = 1'b1;
        end
      end
      OP_SHIFT: begin
        // survivor re-enters at the tail of the live run, else pull from the right
        if (at_tail && ctl.kept) begin
          slot_next = head;
        end else begin
          slot_next = right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_in <= 1'b0;
      now_in <= 1'b0;
      seen   <= 1'b0;
    end else begin
      was_in <= slot_next.was_in;
      now_in <= slot_next.now_in;
      seen   <= slot_next.seen;
    end
  end

  always_ff @(posedge clk) begin
    obj <= slot_next.obj;
  end

endmodule

`default_nettype wire

// ----- src/zoet_checker.sv -----
// zoet_checker: port-level assertions for the zone occupancy tracker
// depends on zoet_pkg; bound to zone_occupancy_edge_tracker below
`default_nettype none

module zoet_checker import zoet_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic [TALLY_W-1:0] entered,
  input wire logic [TALLY_W-1:0] left
);

  // a stalled result keeps its valid and payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(entered) && $stable(left))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // every accepted item makes the block busy and drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready high right after a transaction");

  // a result appears only while the block is not taking items
  a_result_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result rose without a frame end in progress");

endmodule

bind zone_occupancy_edge_tracker zoet_checker u_zoet_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .entered      (result.entered),
  .left         (result.left)
);

`default_nettype wire
